FILE: sv/ufqd_pkg.sv
package ufqd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [1:0] ESC_IDLE  = 2'd0;
    localparam logic [1:0] ESC_FIRST = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;
    localparam logic [1:0] ESC_UNUSED = 2'd3;

    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_EQ      = 8'h3d;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CASE_MASK    = 8'hdf;
    localparam logic [7:0] LETTER_BASE  = 8'd10;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       pair_valid;
        logic       msg_last;
    } rsp_t;

    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        if (c >= CHAR_UPPER_A)
        begin
            d = (c & CASE_MASK) - CHAR_UPPER_A + LETTER_BASE;
        end
        else
        begin
            d = c - CHAR_ZERO;
        end
        return d;
    endfunction

endpackage

FILE: sv/url_form_query_decoder.sv
// Form-encoded query decoder. One character enters per transfer on req (with
// in_last on the final character); decoded name and value bytes and pair end
// records leave on rsp. A character is taken every clock while req_stall is low:
// it lands in an input register, is decoded from there into at most two records,
// and those go into a four-entry result queue. The input register drains only
// while the queue has room for two records, which sets the rate at one
// character per clock while rsp keeps pace; a stalled rsp backs up into req once
// more than two records wait in the queue and the input register holds a
// character. Records with pair_valid low at pair end belong to a pair with no
// '=' and are meant to be discarded with their bytes.
module url_form_query_decoder
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ufqd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ufqd_pkg::rsp_t rsp
);

    import ufqd_pkg::*;

    logic       hold_vld_reg;
    req_t       hold_reg;

    logic       value_part_reg, value_part_next;
    logic [1:0] esc_phase_reg, esc_phase_next;
    logic [7:0] esc_high_reg, esc_high_next;
    logic       nonempty_reg, nonempty_next;

    rsp_t                q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;

    logic       proc;
    logic       pop;
    logic       push_in;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] dig;
    logic [1:0] kind_cur;
    logic       emit_byte;
    logic       emit_end;
    logic [7:0] byte_val;
    logic       end_valid;
    logic       end_last;
    rsp_t       rec0, rec1;
    logic [1:0] n_rec;

    assign proc      = hold_vld_reg && (count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign req_stall = hold_vld_reg && !proc;
    assign push_in   = req_valid && !req_stall;
    assign rsp_valid = (count_reg != '0);
    assign rsp       = q_mem_reg[rd_ptr_reg];
    assign pop       = rsp_valid && !rsp_stall;

    assign b        = hold_reg.in_byte;
    assign c        = (b == CHAR_PLUS) ? CHAR_SPACE : b;
    assign dig      = hex_digit(c);
    assign kind_cur = value_part_reg ? KIND_VALUE : KIND_NAME;

    always_comb
    begin
        value_part_next = value_part_reg;
        esc_phase_next  = esc_phase_reg;
        esc_high_next   = esc_high_reg;
        nonempty_next   = nonempty_reg;
        emit_byte       = 1'b0;
        emit_end        = 1'b0;
        byte_val        = c;
        end_valid       = 1'b0;
        end_last        = hold_reg.in_last;
        if (b == CHAR_AMP)
        begin
            emit_end        = nonempty_reg || hold_reg.in_last;
            end_valid       = value_part_reg;
            value_part_next = 1'b0;
            esc_phase_next  = ESC_IDLE;
            esc_high_next   = '0;
            nonempty_next   = 1'b0;
        end
        else
        begin
            nonempty_next = 1'b1;
            if (b == CHAR_EQ && !value_part_reg)
            begin
                value_part_next = 1'b1;
                esc_phase_next  = ESC_IDLE;
                esc_high_next   = '0;
            end
            else
            begin
                case (esc_phase_reg)
                    ESC_FIRST:
                    begin
                        esc_high_next  = dig;
                        esc_phase_next = ESC_SECOND;
                    end
                    ESC_SECOND:
                    begin
                        emit_byte      = 1'b1;
                        byte_val       = {esc_high_reg[3:0], 4'b0000} + dig;
                        esc_phase_next = ESC_IDLE;
                        esc_high_next  = '0;
                    end
                    default:
                    begin
                        if (c == CHAR_PERCENT)
                        begin
                            esc_phase_next = ESC_FIRST;
                        end
                        else
                        begin
                            esc_phase_next = ESC_IDLE;
                            emit_byte      = 1'b1;
                        end
                    end
                endcase
            end
            if (hold_reg.in_last)
            begin
                emit_end        = 1'b1;
                end_valid       = value_part_next;
                value_part_next = 1'b0;
                esc_phase_next  = ESC_IDLE;
                esc_high_next   = '0;
                nonempty_next   = 1'b0;
            end
        end
    end

    always_comb
    begin
        rsp_t byte_rec;
        rsp_t end_rec;
        byte_rec = '{out_byte: byte_val, kind: kind_cur, pair_valid: 1'b0, msg_last: 1'b0};
        end_rec  = '{out_byte: 8'd0, kind: KIND_END, pair_valid: end_valid,
                     msg_last: end_last};
        rec0     = emit_byte ? byte_rec : end_rec;
        rec1     = end_rec;
        n_rec    = 2'(emit_byte) + 2'(emit_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg   <= 1'b0;
            value_part_reg <= 1'b0;
            esc_phase_reg  <= ESC_IDLE;
            esc_high_reg   <= '0;
            nonempty_reg   <= 1'b0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (push_in)
            begin
                hold_vld_reg <= 1'b1;
            end
            else if (proc)
            begin
                hold_vld_reg <= 1'b0;
            end
            if (proc)
            begin
                value_part_reg <= value_part_next;
                esc_phase_reg  <= esc_phase_next;
                esc_high_reg   <= esc_high_next;
                nonempty_reg   <= nonempty_next;
                wr_ptr_reg     <= wr_ptr_reg + QUEUE_AW'(n_rec);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_reg + (proc ? QUEUE_CW'(n_rec) : '0) - QUEUE_CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in)
        begin
            hold_reg <= req;
        end
        if (proc && n_rec != 2'd0)
        begin
            q_mem_reg[wr_ptr_reg] <= rec0;
        end
        if (proc && n_rec == 2'd2)
        begin
            q_mem_reg[wr_ptr_reg + QUEUE_AW'(1)] <= rec1;
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        proc && hold_reg.in_last |=> !value_part_reg && esc_phase_reg == ESC_IDLE
            && !nonempty_reg)
        else $error("pair state not cleared after last character");

    assert property (@(posedge clk) disable iff (!rst_n)
        esc_phase_reg != ESC_UNUSED)
        else $error("illegal escape phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.msg_last |-> rsp.kind == KIND_END)
        else $error("msg_last on a data record");
`endif

endmodule
